// ----- rtl/core/wsfe_pkg.sv -----
// wsfe_pkg: shared types and constants of the websocket client frame encoder
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps

package wsfe_pkg;

  // start item versus payload item
  typedef enum logic {
    ReqStart = 1'b0,
    ReqData  = 1'b1
  } req_e;

  // one output beat of the byte stream
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
    logic       err;
  } beat_t;

  // header bytes that follow the first one: at most 1 + 8 + 4
  localparam int unsigned HdrTailMax = 13;
  localparam int unsigned HdrCntW    = 4;

  localparam logic [7:0]  FinBit    = 8'h80;
  localparam logic [7:0]  MaskBit   = 8'h80;
  localparam logic [6:0]  Len16Code = 7'h7E;
  localparam logic [6:0]  Len64Code = 7'h7F;
  localparam logic [62:0] Len7Lim   = 63'd126;
  localparam logic [62:0] Len16Lim  = 63'd65536;

  localparam logic [HdrCntW-1:0] TailShort = 4'd5;
  localparam logic [HdrCntW-1:0] TailMid   = 4'd7;
  localparam logic [HdrCntW-1:0] TailLong  = 4'd13;

endpackage

// ----- rtl/core/wsfe_frame_state.sv -----
// wsfe_frame_state: open-frame state and the masked payload beat
// depends on wsfe_pkg
`timescale 1ns / 1ps

module wsfe_frame_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_fire_i,
  input  logic              data_fire_i,
  input  logic [62:0]       payload_length_i,
  input  logic [31:0]       mask_key_i,
  input  logic [7:0]        data_byte_i,
  output wsfe_pkg::beat_t   data_beat_o
);

  logic [62:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic        open_q, open_d;
  logic        fin;

  // last payload byte of the frame
  assign fin = (remain_q == 63'd1);

  // result beat for a payload item
  always_comb begin
    data_beat_o = '0;
    if (open_q) begin
      data_beat_o.data = data_byte_i ^ key_q[8*idx_q +: 8];
      data_beat_o.last = fin;
    end else begin
      data_beat_o.err = 1'b1;
    end
  end

  // next state
  always_comb begin
    remain_d = remain_q;
    key_d    = key_q;
    idx_d    = idx_q;
    open_d   = open_q;
    if (start_fire_i) begin
      remain_d = payload_length_i;
      key_d    = mask_key_i;
      idx_d    = 2'd0;
      open_d   = (payload_length_i != 63'd0);
    end else if (data_fire_i && open_q) begin
      remain_d = remain_q - 63'd1;
      idx_d    = idx_q + 2'd1;
      open_d   = !fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      open_q   <= 1'b0;
    end else begin
      remain_q <= remain_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      open_q   <= open_d;
    end
  end

endmodule

// ----- rtl/core/wsfe_hdr_ser.sv -----
// wsfe_hdr_ser: builds the header bytes after the first and shifts them out
// depends on wsfe_pkg
`timescale 1ns / 1ps

module wsfe_hdr_ser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          shift_i,
  input  logic [62:0]                   payload_length_i,
  input  logic [31:0]                   mask_key_i,
  output logic                          busy_o,
  output wsfe_pkg::beat_t               beat_o
);

  logic [7:0]                  bytes_q [wsfe_pkg::HdrTailMax];
  logic [7:0]                  bytes_d [wsfe_pkg::HdrTailMax];
  logic [7:0]                  tail    [wsfe_pkg::HdrTailMax];
  logic [wsfe_pkg::HdrCntW-1:0] cnt_q, cnt_d, tail_cnt;
  logic [63:0]                 len64;

  assign len64 = {1'b0, payload_length_i};

  // length code, extended length and key bytes for a new frame
  always_comb begin
    for (int i = 0; i < wsfe_pkg::HdrTailMax; i++) begin
      tail[i] = '0;
    end
    if (payload_length_i < wsfe_pkg::Len7Lim) begin
      tail[0]  = wsfe_pkg::MaskBit | {1'b0, payload_length_i[6:0]};
      for (int k = 0; k < 4; k++) begin
        tail[1+k] = mask_key_i[8*k +: 8];
      end
      tail_cnt = wsfe_pkg::TailShort;
    end else if (payload_length_i < wsfe_pkg::Len16Lim) begin
      tail[0]  = wsfe_pkg::MaskBit | {1'b0, wsfe_pkg::Len16Code};
      tail[1]  = payload_length_i[15:8];
      tail[2]  = payload_length_i[7:0];
      for (int k = 0; k < 4; k++) begin
        tail[3+k] = mask_key_i[8*k +: 8];
      end
      tail_cnt = wsfe_pkg::TailMid;
    end else begin
      tail[0]  = wsfe_pkg::MaskBit | {1'b0, wsfe_pkg::Len64Code};
      for (int b = 0; b < 8; b++) begin
        tail[1+b] = len64[63-8*b -: 8];
      end
      for (int k = 0; k < 4; k++) begin
        tail[9+k] = mask_key_i[8*k +: 8];
      end
      tail_cnt = wsfe_pkg::TailLong;
    end
  end

  // load or shift toward the head
  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      bytes_d = tail;
      cnt_d   = tail_cnt;
    end else if (shift_i && busy_o) begin
      for (int i = 0; i < wsfe_pkg::HdrTailMax - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[wsfe_pkg::HdrTailMax-1] = '0;
      cnt_d = cnt_q - {{(wsfe_pkg::HdrCntW-1){1'b0}}, 1'b1};
    end
  end

  assign busy_o = (cnt_q != '0);

  // head beat; the final key byte closes the run
  always_comb begin
    beat_o      = '0;
    beat_o.data = bytes_q[0];
    beat_o.hdr  = 1'b1;
    beat_o.last = (cnt_q == {{(wsfe_pkg::HdrCntW-1){1'b0}}, 1'b1});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

// ----- rtl/core/websocket_frame_encoder.sv -----
// websocket_frame_encoder: masked client frame encoder, top level
// depends on wsfe_pkg, wsfe_frame_state and wsfe_hdr_ser
//
//   channel  dir  handshake              beat
//   in       in   in_valid_i/in_ready_o  req_type, opcode, payload_length, mask_key, data_byte
//   out      out  out_valid_o/out_ready_i out_byte, is_header, last, error
//
// a payload item gives one beat, one per cycle sustained while the output is taken
// a start item gives 6, 8 or 14 header beats, one per cycle while the output is taken, from the header
// shift register; input is held off until its final beat is in the output register
// reset clears the frame state, the header count and the output valid
// the output register refills in the cycle it is taken, so a stall on the
// output side stops input only while that register is full and not taken
`timescale 1ns / 1ps

module websocket_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  opcode_i,
  input  logic [62:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_header_o,
  output logic        last_o,
  output logic        error_o
);

  wsfe_pkg::beat_t out_q, out_d, data_beat, hdr_beat, first_beat;
  logic            out_valid_q, out_valid_d;
  logic            out_free, in_fire, start_fire, data_fire, hdr_busy;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free && !hdr_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_fire = in_fire && (wsfe_pkg::req_e'(req_type_i) == wsfe_pkg::ReqStart);
  assign data_fire  = in_fire && (wsfe_pkg::req_e'(req_type_i) == wsfe_pkg::ReqData);

  wsfe_frame_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_fire_i     (start_fire),
    .data_fire_i      (data_fire),
    .payload_length_i (payload_length_i),
    .mask_key_i       (mask_key_i),
    .data_byte_i      (data_byte_i),
    .data_beat_o      (data_beat)
  );

  wsfe_hdr_ser u_hdr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (start_fire),
    .shift_i          (out_free),
    .payload_length_i (payload_length_i),
    .mask_key_i       (mask_key_i),
    .busy_o           (hdr_busy),
    .beat_o           (hdr_beat)
  );

  // fin and opcode byte
  always_comb begin
    first_beat      = '0;
    first_beat.data = wsfe_pkg::FinBit | {4'd0, opcode_i};
    first_beat.hdr  = 1'b1;
  end

  // output register source select
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      priority if (start_fire) begin
        out_d       = first_beat;
        out_valid_d = 1'b1;
      end else if (data_fire) begin
        out_d       = data_beat;
        out_valid_d = 1'b1;
      end else if (hdr_busy) begin
        out_d       = hdr_beat;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q.data;
  assign is_header_o = out_q.hdr;
  assign last_o      = out_q.last;
  assign error_o     = out_q.err;

endmodule

// ----- test/websocket_frame_encoder_checker.sv -----
// websocket_frame_encoder_checker: watches both channels of the frame encoder,
// predicts every output beat from the accepted input beats and compares them
// depends on wsfe_pkg for the beat layout, request kinds and header constants
`timescale 1ns / 1ps

module websocket_frame_encoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [3:0]  opcode_i,
  input  logic [62:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        is_header_i,
  input  logic        last_i,
  input  logic        error_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // keep the log short when something goes badly wrong
  localparam int unsigned ReportCap = 40;

  // predicted frame state
  logic [62:0] left_bytes;
  logic [31:0] frame_key;
  logic [1:0]  key_pos;
  logic        frame_live;

  // wire bytes still owed by the encoder, oldest first
  wsfe_pkg::beat_t due_beats[$];
  wsfe_pkg::beat_t seen_beat;

  assign seen_beat = {out_byte_i, is_header_i, last_i, error_i};

  function automatic void queue_beat(input logic [7:0] data, input logic hdr,
                                     input logic last, input logic err);
    wsfe_pkg::beat_t b;
    b = {data, hdr, last, err};
    due_beats.push_back(b);
  endfunction

  // expected wire bytes for one accepted input beat
  task automatic encode_item(input wsfe_pkg::req_e kind, input logic [3:0] op,
                             input logic [62:0] len, input logic [31:0] key,
                             input logic [7:0] din);
    logic [63:0] len64;
    int i;
    len64 = {1'b0, len};
    if (kind == wsfe_pkg::ReqStart) begin
      queue_beat(wsfe_pkg::FinBit | {4'b0000, op}, 1'b1, 1'b0, 1'b0);
      // 7-bit, 16-bit or 64-bit length encoding
      if (len < wsfe_pkg::Len7Lim) begin
        queue_beat(wsfe_pkg::MaskBit | {1'b0, len[6:0]}, 1'b1, 1'b0, 1'b0);
      end else if (len < wsfe_pkg::Len16Lim) begin
        queue_beat(wsfe_pkg::MaskBit | {1'b0, wsfe_pkg::Len16Code}, 1'b1, 1'b0, 1'b0);
        queue_beat(len[15:8], 1'b1, 1'b0, 1'b0);
        queue_beat(len[7:0], 1'b1, 1'b0, 1'b0);
      end else begin
        queue_beat(wsfe_pkg::MaskBit | {1'b0, wsfe_pkg::Len64Code}, 1'b1, 1'b0, 1'b0);
        for (i = 7; i >= 0; i--) begin
          queue_beat(len64[8*i +: 8], 1'b1, 1'b0, 1'b0);
        end
      end
      // mask key, low byte first, closes the header run
      for (i = 0; i < 4; i++) begin
        queue_beat(key[8*i +: 8], 1'b1, i == 3, 1'b0);
      end
      frame_key  = key;
      key_pos    = 2'd0;
      left_bytes = len;
      frame_live = (len != '0);
    end else if (!frame_live) begin
      // stray payload byte gives an error beat with a zero byte
      queue_beat(8'h00, 1'b0, 1'b0, 1'b1);
    end else begin
      left_bytes = left_bytes - 63'd1;
      queue_beat(din ^ frame_key[8*key_pos +: 8], 1'b0, left_bytes == '0, 1'b0);
      key_pos = key_pos + 2'd1;
      if (left_bytes == '0) begin
        frame_live = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count_o < ReportCap) begin
      $display("checker: %0t ns: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  // compare one output beat with the oldest expectation
  task automatic check_beat(input wsfe_pkg::beat_t got);
    wsfe_pkg::beat_t want;
    if (due_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat byte %02h hdr %0b last %0b err %0b",
                                got.data, got.hdr, got.last, got.err));
      return;
    end
    want = due_beats.pop_front();
    if (got.data != want.data) begin
      report_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
    end
    if (got.hdr != want.hdr) begin
      report_mismatch($sformatf("is_header %0b, want %0b", got.hdr, want.hdr));
    end
    if (got.last != want.last) begin
      report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
    if (got.err != want.err) begin
      report_mismatch($sformatf("error %0b, want %0b", got.err, want.err));
    end
  endtask

  // input beats are predicted before the output beat of the same edge is checked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bytes   = '0;
      frame_key    = '0;
      key_pos      = '0;
      frame_live   = 1'b0;
      due_beats.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        encode_item(wsfe_pkg::req_e'(req_type_i), opcode_i, payload_length_i,
                    mask_key_i, data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_beat(seen_beat);
      end
      pending_o = due_beats.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// testbench: top of the frame encoder test, drives start and payload beats
// with random gaps and output stalls, checker compares the byte stream
// depends on wsfe_pkg, websocket_frame_encoder and websocket_frame_encoder_checker
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PhaseItems = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [3:0]  opcode;
  logic [62:0] payload_length;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_header;
  logic        out_last;
  logic        out_error;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent      = 0;
  int unsigned idle_pct        = 0;
  int unsigned stall_pct       = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cycles    = 0;

  always #6 clk_i = ~clk_i;

  websocket_frame_encoder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .opcode_i         (opcode),
    .payload_length_i (payload_length),
    .mask_key_i       (mask_key),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_o       (out_byte),
    .is_header_o      (out_header),
    .last_o           (out_last),
    .error_o          (out_error)
  );

  websocket_frame_encoder_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .req_type_i       (req_type),
    .opcode_i         (opcode),
    .payload_length_i (payload_length),
    .mask_key_i       (mask_key),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_i       (out_byte),
    .is_header_i      (out_header),
    .last_i           (out_last),
    .error_i          (out_error),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // offer one input beat after a random gap, return at the falling edge after accept
  task automatic send_item(input wsfe_pkg::req_e kind, input logic [3:0] op,
                           input logic [62:0] len, input logic [31:0] key,
                           input logic [7:0] din);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    req_type       <= kind;
    opcode         <= op;
    payload_length <= len;
    mask_key       <= key;
    data_byte      <= din;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // start beat with junk in the payload byte field
  task automatic send_start(input logic [3:0] op, input logic [62:0] len,
                            input logic [31:0] key);
    send_item(wsfe_pkg::ReqStart, op, len, key, 8'($urandom_range(255)));
  endtask

  // payload beat with junk in the header fields
  task automatic send_byte(input logic [7:0] din);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    send_item(wsfe_pkg::ReqData, 4'($urandom_range(15)), junk[62:0], $urandom, din);
  endtask

  // stop offering until every predicted byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // output side: random stalls, or one long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk_i);
        hold_off_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // end the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    int unsigned roll;
    int unsigned n;
    logic [63:0] wide;
    logic [62:0] len;

    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    req_type       = 1'b0;
    opcode         = '0;
    payload_length = '0;
    mask_key       = '0;
    data_byte      = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: stray byte after reset, empty frame, length code boundaries
    send_byte(8'hA5);
    send_start(4'h0, 63'd0, 32'h0000_0000);
    send_byte(8'h3C);
    send_start(4'hF, 63'd125, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_start(4'h1, 63'd126, 32'h1234_5678);
    send_byte(8'h55);
    send_start(4'h2, 63'd65535, 32'h8765_4321);
    send_byte(8'hAA);
    send_start(4'h8, 63'd65536, 32'hA5A5_5A5A);
    send_byte(8'h0F);
    send_start(4'h9, {63{1'b1}}, 32'h0F0F_F0F0);
    send_byte(8'hF0);
    // single byte frame closes, next byte is stray
    send_start(4'hA, 63'd1, 32'hDEAD_BEEF);
    send_byte(8'h81);
    send_byte(8'h7E);
    // key index wraps past the fourth byte
    send_start(4'h2, 63'd5, 32'h0403_0201);
    for (n = 0; n < 5; n++) begin
      send_byte(8'h10 + n[7:0]);
    end
    wait_drained();

    // long output hold-off while a full 126 byte frame is offered back to back
    hold_off_cycles = 200;
    send_start(4'h2, 63'd126, $urandom);
    repeat (126) send_byte(8'($urandom_range(255)));
    wait_drained();

    // random frames: no idling, sender idle, receiver stalls, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          // complete short frame, sometimes followed by a stray byte
          len = 63'($urandom_range(12, 1));
          send_start(4'($urandom_range(15)), len, $urandom);
          repeat (len) send_byte(8'($urandom_range(255)));
          if ($urandom_range(4) == 0) begin
            send_byte(8'($urandom_range(255)));
          end
        end else if (roll < 75) begin
          // empty frame then stray bytes
          send_start(4'($urandom_range(15)), 63'd0, $urandom);
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end else if (roll < 85) begin
          // extended length, abandoned after at most three bytes
          if ($urandom_range(1)) begin
            len = 63'($urandom_range(65535, 126));
          end else begin
            wide = {$urandom, $urandom};
            len  = wide[62:0];
            if (len < wsfe_pkg::Len16Lim) begin
              len = len + wsfe_pkg::Len16Lim;
            end
          end
          send_start(4'($urandom_range(15)), len, $urandom);
          repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
        end else begin
          // short frame cut off by the next start
          len = 63'($urandom_range(12, 2));
          send_start(4'($urandom_range(15)), len, $urandom);
          repeat ($urandom_range(32'(len - 63'd1))) send_byte(8'($urandom_range(255)));
        end
      end
      wait_drained();
    end

    // let any late beat show up before the verdict
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/wsfe_pkg.sv
rtl/core/wsfe_frame_state.sv
rtl/core/wsfe_hdr_ser.sv
rtl/core/websocket_frame_encoder.sv
test/websocket_frame_encoder_checker.sv
test/testbench.sv
